### hdl/c8_pkg.sv
// c8_pkg: shared types, codes and constants of the chip-8 instruction core
// no dependencies; used by c8_ctrl, c8_dpath and chip8_instruction_core
package c8_pkg;

  localparam int MEM_BYTES   = 4096;
  localparam int MEM_AW      = 12;
  localparam int SCREEN_ROWS = 32;
  localparam int SCREEN_COLS = 64;
  localparam int FONT_BYTES  = 80;
  localparam int NUM_REGS    = 16;
  localparam logic [11:0] PC_RESET = 12'd512;

  // built-in hex font, five rows per digit
  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // request types
  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_KEY   = 3'd2;
  localparam logic [2:0] REQ_EXEC  = 3'd3;
  localparam logic [2:0] REQ_ROW   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] OPG_SYS  = 4'h0;
  localparam logic [3:0] OPG_JP   = 4'h1;
  localparam logic [3:0] OPG_CALL = 4'h2;
  localparam logic [3:0] OPG_SE   = 4'h3;
  localparam logic [3:0] OPG_SNE  = 4'h4;
  localparam logic [3:0] OPG_SER  = 4'h5;
  localparam logic [3:0] OPG_LD   = 4'h6;
  localparam logic [3:0] OPG_ADD  = 4'h7;
  localparam logic [3:0] OPG_ALU  = 4'h8;
  localparam logic [3:0] OPG_SNER = 4'h9;
  localparam logic [3:0] OPG_LDI  = 4'hA;
  localparam logic [3:0] OPG_JPV  = 4'hB;
  localparam logic [3:0] OPG_RND  = 4'hC;
  localparam logic [3:0] OPG_DRW  = 4'hD;
  localparam logic [3:0] OPG_KEY  = 4'hE;
  localparam logic [3:0] OPG_MISC = 4'hF;

  // alu group sub-codes
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // low-byte sub-codes
  localparam logic [7:0] LO_CLS   = 8'hE0;
  localparam logic [7:0] LO_RET   = 8'hEE;
  localparam logic [7:0] LO_SKP   = 8'h9E;
  localparam logic [7:0] LO_SKNP  = 8'hA1;
  localparam logic [7:0] LO_WAITK = 8'h0A;
  localparam logic [7:0] LO_TIMER = 8'h18;
  localparam logic [7:0] LO_ADDI  = 8'h1E;
  localparam logic [7:0] LO_FONT  = 8'h29;
  localparam logic [7:0] LO_BCD   = 8'h33;
  localparam logic [7:0] LO_STORE = 8'h55;
  localparam logic [7:0] LO_LOAD  = 8'h65;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDMEM, S_FETCH_HI, S_FETCH_LO, S_DEC, S_RD_X, S_RD_Y,
    S_EXEC, S_DRAW_RD, S_DRAW_WR, S_VF, S_BCD0, S_BCD1, S_BCD2,
    S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_RESP
  } c8_state_t;

  typedef enum logic [4:0] {
    OP_CLEAR, OP_IDLE, OP_ACCEPT, OP_RDMEM, OP_FETCH_HI, OP_FETCH_LO, OP_DEC,
    OP_RD_X, OP_RD_Y, OP_EXEC, OP_DRAW_RD, OP_DRAW_WR, OP_VF, OP_BCD0,
    OP_BCD1, OP_BCD2, OP_ST_RD, OP_ST_WR, OP_LD_RD, OP_LD_WR, OP_RESP
  } c8_cmd_t;

  // how an instruction finishes after its execute cycle
  typedef enum logic [2:0] {
    K_SINGLE, K_FLAG, K_DRAW, K_BCD, K_STORE, K_LOAD
  } c8_kind_t;

  typedef struct packed {
    c8_kind_t kind;
    logic     draw_empty;
    logic     loop_last;
    logic     clear_last;
    logic     out_free;
    logic     exec_blocked;
  } c8_stat_t;

endpackage

### hdl/chip8_instruction_core.sv
// Chip-8 instruction core. After reset a clearing pass over every memory address
// loads the font and zeroes memory, registers and stack; no item is taken meanwhile.
// Then one item is worked at a time through a memory with one write port and
// one registered read port. Byte write, key event and row read go straight to
// the result register; byte read adds a memory read; an instruction fetches two
// bytes, decodes, reads Vx and Vy and executes, then writes VF for a flag or a
// sprite, reads and writes each sprite row, writes three BCD digits, or reads and
// writes each of X+1 entries for register store or load, one entry at a time.
// A program start write reloads the program counter at once.
// top level: joins c8_ctrl and c8_dpath; depends on c8_pkg
module chip8_instruction_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_program_start,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [11:0] in_mem_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [3:0]  in_key_index,
  input  logic        in_key_down,
  input  logic [7:0]  in_random_byte,
  input  logic [4:0]  in_row_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_read_byte,
  output logic [63:0] out_screen_row,
  output logic [11:0] out_pc_now
);

  c8_pkg::c8_stat_t stat;
  c8_pkg::c8_cmd_t  cmd;

  // configuration beat is always taken
  assign cfg_ready = 1'b1;

  c8_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .stat        (stat),
    .in_ready    (in_ready),
    .cmd         (cmd)
  );

  c8_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid),
    .cfg_program_start (cfg_program_start),
    .in_req_type       (in_req_type),
    .in_mem_addr       (in_mem_addr),
    .in_write_byte     (in_write_byte),
    .in_key_index      (in_key_index),
    .in_key_down       (in_key_down),
    .in_random_byte    (in_random_byte),
    .in_row_select     (in_row_select),
    .out_ready         (out_ready),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_byte     (out_read_byte),
    .out_screen_row    (out_screen_row),
    .out_pc_now        (out_pc_now)
  );

endmodule

### hdl/c8_ctrl.sv
// c8_ctrl: sequencing state machine of the chip-8 core
// depends on c8_pkg; drives c8_dpath through a command code
module c8_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_req_type,
  input  c8_pkg::c8_stat_t stat,
  output logic             in_ready,
  output c8_pkg::c8_cmd_t  cmd
);

  c8_pkg::c8_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = c8_pkg::OP_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      c8_pkg::S_CLEAR: begin
        cmd = c8_pkg::OP_CLEAR;
        if (stat.clear_last) state_nxt = c8_pkg::S_IDLE;
      end
      c8_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = c8_pkg::OP_ACCEPT;
          if (in_req_type == c8_pkg::REQ_READ) begin
            state_nxt = c8_pkg::S_RDMEM;
          end else if (in_req_type == c8_pkg::REQ_EXEC && !stat.exec_blocked) begin
            state_nxt = c8_pkg::S_FETCH_HI;
          end else begin
            state_nxt = c8_pkg::S_RESP;
          end
        end
      end
      c8_pkg::S_RDMEM: begin
        cmd = c8_pkg::OP_RDMEM;
        state_nxt = c8_pkg::S_RESP;
      end
      c8_pkg::S_FETCH_HI: begin
        cmd = c8_pkg::OP_FETCH_HI;
        state_nxt = c8_pkg::S_FETCH_LO;
      end
      c8_pkg::S_FETCH_LO: begin
        cmd = c8_pkg::OP_FETCH_LO;
        state_nxt = c8_pkg::S_DEC;
      end
      c8_pkg::S_DEC: begin
        cmd = c8_pkg::OP_DEC;
        state_nxt = c8_pkg::S_RD_X;
      end
      c8_pkg::S_RD_X: begin
        cmd = c8_pkg::OP_RD_X;
        state_nxt = c8_pkg::S_RD_Y;
      end
      c8_pkg::S_RD_Y: begin
        cmd = c8_pkg::OP_RD_Y;
        state_nxt = c8_pkg::S_EXEC;
      end
      c8_pkg::S_EXEC: begin
        cmd = c8_pkg::OP_EXEC;
        unique case (stat.kind)
          c8_pkg::K_FLAG:  state_nxt = c8_pkg::S_VF;
          c8_pkg::K_DRAW:  state_nxt = stat.draw_empty ? c8_pkg::S_VF : c8_pkg::S_DRAW_RD;
          c8_pkg::K_BCD:   state_nxt = c8_pkg::S_BCD0;
          c8_pkg::K_STORE: state_nxt = c8_pkg::S_ST_RD;
          c8_pkg::K_LOAD:  state_nxt = c8_pkg::S_LD_RD;
          default:         state_nxt = c8_pkg::S_RESP;
        endcase
      end
      c8_pkg::S_DRAW_RD: begin
        cmd = c8_pkg::OP_DRAW_RD;
        state_nxt = c8_pkg::S_DRAW_WR;
      end
      c8_pkg::S_DRAW_WR: begin
        cmd = c8_pkg::OP_DRAW_WR;
        state_nxt = stat.loop_last ? c8_pkg::S_VF : c8_pkg::S_DRAW_RD;
      end
      c8_pkg::S_VF: begin
        cmd = c8_pkg::OP_VF;
        state_nxt = c8_pkg::S_RESP;
      end
      c8_pkg::S_BCD0: begin
        cmd = c8_pkg::OP_BCD0;
        state_nxt = c8_pkg::S_BCD1;
      end
      c8_pkg::S_BCD1: begin
        cmd = c8_pkg::OP_BCD1;
        state_nxt = c8_pkg::S_BCD2;
      end
      c8_pkg::S_BCD2: begin
        cmd = c8_pkg::OP_BCD2;
        state_nxt = c8_pkg::S_RESP;
      end
      c8_pkg::S_ST_RD: begin
        cmd = c8_pkg::OP_ST_RD;
        state_nxt = c8_pkg::S_ST_WR;
      end
      c8_pkg::S_ST_WR: begin
        cmd = c8_pkg::OP_ST_WR;
        state_nxt = stat.loop_last ? c8_pkg::S_RESP : c8_pkg::S_ST_RD;
      end
      c8_pkg::S_LD_RD: begin
        cmd = c8_pkg::OP_LD_RD;
        state_nxt = c8_pkg::S_LD_WR;
      end
      c8_pkg::S_LD_WR: begin
        cmd = c8_pkg::OP_LD_WR;
        state_nxt = stat.loop_last ? c8_pkg::S_RESP : c8_pkg::S_LD_RD;
      end
      c8_pkg::S_RESP: begin
        cmd = c8_pkg::OP_RESP;
        if (stat.out_free) state_nxt = c8_pkg::S_IDLE;
      end
      default: state_nxt = c8_pkg::S_CLEAR;
    endcase
  end

endmodule

### hdl/c8_dpath.sv
// c8_dpath: memory, register file, stack, screen and execute datapath
// depends on c8_pkg; commanded by c8_ctrl
module c8_dpath #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  c8_pkg::c8_cmd_t  cmd,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_program_start,
  input  logic [2:0]       in_req_type,
  input  logic [11:0]      in_mem_addr,
  input  logic [7:0]       in_write_byte,
  input  logic [3:0]       in_key_index,
  input  logic             in_key_down,
  input  logic [7:0]       in_random_byte,
  input  logic [4:0]       in_row_select,
  input  logic             out_ready,
  output c8_pkg::c8_stat_t stat,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [7:0]       out_read_byte,
  output logic [63:0]      out_screen_row,
  output logic [11:0]      out_pc_now
);

  localparam int SPW = $clog2(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_TOP = SPW'(STACK_DEPTH - 1);

  // storage arrays
  logic [7:0]  mem [c8_pkg::MEM_BYTES];
  logic [7:0]  rf [c8_pkg::NUM_REGS];
  logic [11:0] stk [STACK_DEPTH];
  logic [63:0] scr_r [c8_pkg::SCREEN_ROWS];

  logic [7:0]  mem_q_r, rf_q_r;
  logic [11:0] stk_q_r;
  logic        mem_we, rf_we, stk_we, scr_we, scr_clear;
  logic [11:0] mem_wa, mem_ra, stk_wd;
  logic [7:0]  mem_wd, rf_wd;
  logic [3:0]  rf_wa, rf_ra;
  logic [SPW-1:0] stk_wa, sp_dec, sp_inc;
  logic [4:0]  scr_wa;
  logic [63:0] scr_wd;

  // architectural and sequencing registers
  logic [11:0] pc_r, pc_nxt;
  logic [15:0] i_r, i_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [15:0] keys_r, keys_nxt;
  logic        wait_r, wait_nxt, halt_r, halt_nxt;
  logic [3:0]  tgt_r, tgt_nxt;
  logic [11:0] clr_r, clr_nxt;
  logic [7:0]  hi_r, hi_nxt, lo_r, lo_nxt, vx_r, vx_nxt, vy_r, vy_nxt, rnd_r, rnd_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        hit_r, hit_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic [63:0] row_r, row_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_rd_r, out_rd_nxt;
  logic [63:0] out_row_r, out_row_nxt;
  logic [11:0] out_pc_r, out_pc_nxt;

  // instruction fields and helpers
  logic [3:0]  opg, xi, ni;
  logic [11:0] nnn, pc_next, pc_skip, newpc, i_cnt;
  logic        bad, out_free;
  logic [8:0]  sum9;
  logic [1:0]  hund;
  logic [6:0]  rem_c, ones;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [127:0] rot;
  logic [63:0] line;
  logic [4:0]  draw_row;
  c8_pkg::c8_kind_t kind;

  assign opg      = hi_r[7:4];
  assign xi       = hi_r[3:0];
  assign ni       = lo_r[3:0];
  assign nnn      = {hi_r[3:0], lo_r};
  assign pc_next  = pc_r + 12'd2;
  assign pc_skip  = pc_r + 12'd4;
  assign i_cnt    = i_r[11:0] + {8'd0, cnt_r};
  assign sum9     = {1'b0, vx_r} + {1'b0, vy_r};
  assign sp_dec   = (sp_r == '0) ? SP_TOP : sp_r - 1'b1;
  assign sp_inc   = (sp_r == SP_TOP) ? '0 : sp_r + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  // bcd digits: hundreds by compare, tens by reciprocal multiply
  assign hund      = (vx_r >= 8'd200) ? 2'd2 : ((vx_r >= 8'd100) ? 2'd1 : 2'd0);
  assign rem_c     = 7'(vx_r - 8'(hund) * 8'd100);
  assign tens_prod = 15'(rem_r) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = rem_r - 7'(tens) * 7'd10;

  // sprite line rotated to its column, row wraps in 32
  assign rot      = {mem_q_r, 56'd0, mem_q_r, 56'd0} >> vx_r[5:0];
  assign line     = rot[63:0];
  assign draw_row = vy_r[4:0] + {1'b0, cnt_r};

  // finishing class of the current instruction
  always_comb begin
    kind = c8_pkg::K_SINGLE;
    if (opg == c8_pkg::OPG_DRW) begin
      kind = c8_pkg::K_DRAW;
    end else if (opg == c8_pkg::OPG_ALU &&
                 (ni == c8_pkg::ALU_ADD || ni == c8_pkg::ALU_SUB || ni == c8_pkg::ALU_SHR ||
                  ni == c8_pkg::ALU_SUBN || ni == c8_pkg::ALU_SHL)) begin
      kind = c8_pkg::K_FLAG;
    end else if (opg == c8_pkg::OPG_MISC) begin
      if (lo_r == c8_pkg::LO_BCD)        kind = c8_pkg::K_BCD;
      else if (lo_r == c8_pkg::LO_STORE) kind = c8_pkg::K_STORE;
      else if (lo_r == c8_pkg::LO_LOAD)  kind = c8_pkg::K_LOAD;
    end
  end

  // status toward the controller
  always_comb begin
    stat.kind         = kind;
    stat.draw_empty   = (ni == 4'd0);
    stat.loop_last    = (kind == c8_pkg::K_DRAW) ? (cnt_r == ni - 4'd1) : (cnt_r == xi);
    stat.clear_last   = (clr_r == 12'hFFF);
    stat.out_free     = out_free;
    stat.exec_blocked = halt_r || wait_r;
  end

  // command decode and next state
  always_comb begin
    pc_nxt = pc_r;  i_nxt = i_r;  sp_nxt = sp_r;  keys_nxt = keys_r;
    wait_nxt = wait_r;  halt_nxt = halt_r;  tgt_nxt = tgt_r;  clr_nxt = clr_r;
    hi_nxt = hi_r;  lo_nxt = lo_r;  vx_nxt = vx_r;  vy_nxt = vy_r;  rnd_nxt = rnd_r;
    cnt_nxt = cnt_r;  hit_nxt = hit_r;  rem_nxt = rem_r;  rd_nxt = rd_r;  row_nxt = row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;  out_rd_nxt = out_rd_r;
    out_row_nxt = out_row_r;  out_pc_nxt = out_pc_r;
    mem_we = 1'b0;  mem_wa = i_cnt;  mem_wd = 8'd0;  mem_ra = pc_r;
    rf_we = 1'b0;  rf_wa = xi;  rf_wd = 8'd0;  rf_ra = xi;
    stk_we = 1'b0;  stk_wa = sp_r;  stk_wd = 12'd0;
    scr_we = 1'b0;  scr_clear = 1'b0;  scr_wa = draw_row;  scr_wd = scr_r[draw_row] ^ line;
    newpc = pc_next;  bad = 1'b0;

    unique case (cmd)
      c8_pkg::OP_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = (clr_r < 12'(c8_pkg::FONT_BYTES)) ? c8_pkg::FONT_ROM[clr_r[6:0]] : 8'd0;
        rf_we  = (clr_r < 12'(c8_pkg::NUM_REGS));
        rf_wa  = clr_r[3:0];
        stk_we = (clr_r < 12'(STACK_DEPTH));
        stk_wa = clr_r[SPW-1:0];
        clr_nxt = clr_r + 12'd1;
      end
      c8_pkg::OP_IDLE: ;
      c8_pkg::OP_ACCEPT: begin
        rd_nxt  = 8'd0;
        row_nxt = (in_req_type == c8_pkg::REQ_ROW) ? scr_r[in_row_select] : 64'd0;
        rnd_nxt = in_random_byte;
        mem_ra  = in_mem_addr;
        if (in_req_type == c8_pkg::REQ_WRITE) begin
          mem_we = 1'b1;
          mem_wa = in_mem_addr;
          mem_wd = in_write_byte;
        end
        if (in_req_type == c8_pkg::REQ_KEY) begin
          if (in_key_down) begin
            keys_nxt = keys_r | (16'd1 << in_key_index);
            if (wait_r) begin
              rf_we    = 1'b1;
              rf_wa    = tgt_r;
              rf_wd    = {4'd0, in_key_index};
              wait_nxt = 1'b0;
              pc_nxt   = pc_next;
            end
          end else begin
            keys_nxt = keys_r & ~(16'd1 << in_key_index);
          end
        end
      end
      c8_pkg::OP_RDMEM:    rd_nxt = mem_q_r;
      c8_pkg::OP_FETCH_HI: mem_ra = pc_r;
      c8_pkg::OP_FETCH_LO: begin
        mem_ra = pc_r + 12'd1;
        hi_nxt = mem_q_r;
      end
      c8_pkg::OP_DEC: begin
        lo_nxt = mem_q_r;
        rf_ra  = xi;
      end
      c8_pkg::OP_RD_X: begin
        vx_nxt = rf_q_r;
        rf_ra  = (opg == c8_pkg::OPG_JPV) ? 4'd0 : lo_r[7:4];
      end
      c8_pkg::OP_RD_Y: vy_nxt = rf_q_r;
      c8_pkg::OP_EXEC: begin
        cnt_nxt = 4'd0;
        hit_nxt = 1'b0;
        unique case (opg)
          c8_pkg::OPG_SYS: begin
            if (hi_r != 8'd0) bad = 1'b1;
            else if (lo_r == c8_pkg::LO_CLS) scr_clear = 1'b1;
            else if (lo_r == c8_pkg::LO_RET) begin
              sp_nxt = sp_dec;
              newpc  = stk_q_r + 12'd2;
            end else bad = 1'b1;
          end
          c8_pkg::OPG_JP: newpc = nnn;
          c8_pkg::OPG_CALL: begin
            stk_we = 1'b1;
            stk_wd = pc_r;
            sp_nxt = sp_inc;
            newpc  = nnn;
          end
          c8_pkg::OPG_SE:  if (vx_r == lo_r) newpc = pc_skip;
          c8_pkg::OPG_SNE: if (vx_r != lo_r) newpc = pc_skip;
          c8_pkg::OPG_SER: begin
            if (ni != 4'd0) bad = 1'b1;
            else if (vx_r == vy_r) newpc = pc_skip;
          end
          c8_pkg::OPG_LD: begin
            rf_we = 1'b1;
            rf_wd = lo_r;
          end
          c8_pkg::OPG_ADD: begin
            rf_we = 1'b1;
            rf_wd = vx_r + lo_r;
          end
          c8_pkg::OPG_ALU: begin
            rf_we = 1'b1;
            unique case (ni)
              c8_pkg::ALU_MOV: rf_wd = vy_r;
              c8_pkg::ALU_OR:  rf_wd = vx_r | vy_r;
              c8_pkg::ALU_AND: rf_wd = vx_r & vy_r;
              c8_pkg::ALU_XOR: rf_wd = vx_r ^ vy_r;
              c8_pkg::ALU_ADD: begin
                rf_wd   = sum9[7:0];
                hit_nxt = sum9[8];
              end
              c8_pkg::ALU_SUB: begin
                rf_wd   = vx_r - vy_r;
                hit_nxt = (vx_r >= vy_r);
              end
              c8_pkg::ALU_SHR: begin
                rf_wd   = {1'b0, vx_r[7:1]};
                hit_nxt = vx_r[0];
              end
              c8_pkg::ALU_SUBN: begin
                rf_wd   = vy_r - vx_r;
                hit_nxt = (vy_r >= vx_r);
              end
              c8_pkg::ALU_SHL: begin
                rf_wd   = {vx_r[6:0], 1'b0};
                hit_nxt = vx_r[7];
              end
              default: begin
                rf_we = 1'b0;
                bad   = 1'b1;
              end
            endcase
          end
          c8_pkg::OPG_SNER: begin
            if (ni != 4'd0) bad = 1'b1;
            else if (vx_r != vy_r) newpc = pc_skip;
          end
          c8_pkg::OPG_LDI: i_nxt = {4'd0, nnn};
          c8_pkg::OPG_JPV: newpc = nnn + {4'd0, vy_r};
          c8_pkg::OPG_RND: begin
            rf_we = 1'b1;
            rf_wd = rnd_r & lo_r;
          end
          c8_pkg::OPG_DRW: ;
          c8_pkg::OPG_KEY: begin
            if (lo_r == c8_pkg::LO_SKP) begin
              if (keys_r[vx_r[3:0]]) newpc = pc_skip;
            end else if (lo_r == c8_pkg::LO_SKNP) begin
              if (!keys_r[vx_r[3:0]]) newpc = pc_skip;
            end else bad = 1'b1;
          end
          default: begin
            priority case (lo_r)
              c8_pkg::LO_WAITK: begin
                wait_nxt = 1'b1;
                tgt_nxt  = xi;
                newpc    = pc_r;
              end
              c8_pkg::LO_TIMER: ;
              c8_pkg::LO_ADDI:  i_nxt = i_r + {8'd0, vx_r};
              c8_pkg::LO_FONT:  i_nxt = {10'd0, vx_r[3:0], 2'd0} + {12'd0, vx_r[3:0]};
              c8_pkg::LO_BCD, c8_pkg::LO_STORE, c8_pkg::LO_LOAD: ;
              default: bad = 1'b1;
            endcase
          end
        endcase
        if (bad) halt_nxt = 1'b1;
        else pc_nxt = newpc;
      end
      c8_pkg::OP_DRAW_RD: mem_ra = i_cnt;
      c8_pkg::OP_DRAW_WR: begin
        scr_we  = 1'b1;
        hit_nxt = hit_r || ((scr_r[draw_row] & line) != 64'd0);
        cnt_nxt = cnt_r + 4'd1;
      end
      c8_pkg::OP_VF: begin
        rf_we = 1'b1;
        rf_wa = 4'hF;
        rf_wd = {7'd0, hit_r};
      end
      c8_pkg::OP_BCD0: begin
        mem_we  = 1'b1;
        mem_wa  = i_r[11:0];
        mem_wd  = {6'd0, hund};
        rem_nxt = rem_c;
      end
      c8_pkg::OP_BCD1: begin
        mem_we = 1'b1;
        mem_wa = i_r[11:0] + 12'd1;
        mem_wd = {4'd0, tens};
      end
      c8_pkg::OP_BCD2: begin
        mem_we = 1'b1;
        mem_wa = i_r[11:0] + 12'd2;
        mem_wd = {1'b0, ones};
      end
      c8_pkg::OP_ST_RD: rf_ra = cnt_r;
      c8_pkg::OP_ST_WR: begin
        mem_we  = 1'b1;
        mem_wa  = i_cnt;
        mem_wd  = rf_q_r;
        cnt_nxt = cnt_r + 4'd1;
      end
      c8_pkg::OP_LD_RD: mem_ra = i_cnt;
      c8_pkg::OP_LD_WR: begin
        rf_we   = 1'b1;
        rf_wa   = cnt_r;
        rf_wd   = mem_q_r;
        cnt_nxt = cnt_r + 4'd1;
      end
      c8_pkg::OP_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = halt_r ? c8_pkg::ST_HALT :
                           (wait_r ? c8_pkg::ST_WAIT : c8_pkg::ST_DONE);
          out_rd_nxt     = rd_r;
          out_row_nxt    = row_r;
          out_pc_nxt     = pc_r;
        end
      end
      default: ;
    endcase

    // program start write reloads the program counter
    if (cfg_we) pc_nxt = cfg_program_start;
  end

  // main memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q_r <= mem[mem_ra];
  end

  // register file
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    rf_q_r <= rf[rf_ra];
  end

  // return stack, read ahead at the entry below the pointer
  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_q_r <= stk[sp_dec];
  end

  // screen rows
  always_ff @(posedge clk) begin
    if (!rst_n || scr_clear) begin
      for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) scr_r[r] <= 64'd0;
    end else if (scr_we) begin
      scr_r[scr_wa] <= scr_wd;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= c8_pkg::PC_RESET;
      i_r         <= 16'd0;
      sp_r        <= '0;
      keys_r      <= 16'd0;
      wait_r      <= 1'b0;
      halt_r      <= 1'b0;
      tgt_r       <= 4'd0;
      clr_r       <= 12'd0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      i_r         <= i_nxt;
      sp_r        <= sp_nxt;
      keys_r      <= keys_nxt;
      wait_r      <= wait_nxt;
      halt_r      <= halt_nxt;
      tgt_r       <= tgt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hi_r         <= hi_nxt;
    lo_r         <= lo_nxt;
    vx_r         <= vx_nxt;
    vy_r         <= vy_nxt;
    rnd_r        <= rnd_nxt;
    cnt_r        <= cnt_nxt;
    hit_r        <= hit_nxt;
    rem_r        <= rem_nxt;
    rd_r         <= rd_nxt;
    row_r        <= row_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_row_r    <= out_row_nxt;
    out_pc_r     <= out_pc_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_byte  = out_rd_r;
  assign out_screen_row = out_row_r;
  assign out_pc_now     = out_pc_r;

`ifndef SYNTHESIS
  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt cleared without reset");

  // key wait and halt never coexist
  a_wait_halt: assert property (@(posedge clk) disable iff (!rst_n)
    !(wait_r && halt_r)) else $error("key wait while halted");

  // a halted core keeps its program counter unless reconfigured
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (halt_r && !cfg_we) |=> (pc_r == $past(pc_r))) else $error("pc moved while halted");
`endif

endmodule

### tb/sv/chip8_instruction_core_test.sv
// chip8_instruction_core_test: self-checking bench for the chip-8 instruction core
// depends on c8_pkg and chip8_instruction_core; holds its own model of the core
`timescale 1ns / 1ps

module chip8_instruction_core_test;

  localparam int STACK_N = 16;
  localparam int CYCLE_LIMIT = 2000000;
  // request type that the core does not know
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_program_start = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [11:0] in_mem_addr = '0;
  logic [7:0]  in_write_byte = '0;
  logic [3:0]  in_key_index = '0;
  logic        in_key_down = 1'b0;
  logic [7:0]  in_random_byte = '0;
  logic [4:0]  in_row_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_read_byte;
  logic [63:0] out_screen_row;
  logic [11:0] out_pc_now;

  chip8_instruction_core #(.STACK_DEPTH(STACK_N)) dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_program_start,
    .in_valid, .in_ready, .in_req_type, .in_mem_addr, .in_write_byte,
    .in_key_index, .in_key_down, .in_random_byte, .in_row_select,
    .out_valid, .out_ready, .out_status, .out_read_byte, .out_screen_row,
    .out_pc_now
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rd;
    logic [63:0] row;
    logic [11:0] pc;
  } core_result_t;

  // shadow copy of the core state
  logic [7:0]  sh_mem [c8_pkg::MEM_BYTES];
  logic [7:0]  sh_v [16];
  logic [15:0] sh_i;
  logic [11:0] sh_pc;
  logic [11:0] sh_start;
  logic [11:0] sh_stack [STACK_N];
  int          sh_sp;
  logic [63:0] sh_screen [c8_pkg::SCREEN_ROWS];
  logic [15:0] sh_keys;
  logic        sh_wait;
  logic [3:0]  sh_target;
  logic        sh_halt;

  core_result_t expected_results[$];
  int  mismatches = 0;
  int  beats_sent = 0;
  int  beats_checked = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;     // no idling in the final part
  int  out_stall_left = 0;

  function automatic void shadow_reset();
    for (int a = 0; a < c8_pkg::MEM_BYTES; a++)
      sh_mem[a] = (a < c8_pkg::FONT_BYTES) ? c8_pkg::FONT_ROM[a] : 8'h00;
    for (int r = 0; r < 16; r++) sh_v[r] = '0;
    for (int s = 0; s < STACK_N; s++) sh_stack[s] = '0;
    for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) sh_screen[r] = '0;
    sh_i = '0; sh_start = c8_pkg::PC_RESET; sh_pc = c8_pkg::PC_RESET; sh_sp = 0;
    sh_keys = '0; sh_wait = 0; sh_target = '0; sh_halt = 0;
  endfunction

  // one instruction of the shadow cpu
  function automatic void shadow_execute(logic [7:0] rnd);
    logic [7:0]  hi, lo, vx, vy;
    logic [3:0]  x, y, n;
    logic [11:0] nnn, nxt, skp, npc, a;
    logic [63:0] line;
    logic [8:0]  sum;
    logic        bad, hit;
    int          x0;
    hi = sh_mem[sh_pc]; lo = sh_mem[12'(sh_pc + 12'd1)];
    x = hi[3:0]; y = lo[7:4]; n = lo[3:0]; nnn = {hi[3:0], lo};
    vx = sh_v[x]; vy = sh_v[y];
    nxt = sh_pc + 12'd2; skp = sh_pc + 12'd4; npc = nxt; bad = 0;
    case (hi[7:4])
      c8_pkg::OPG_SYS: begin
        if (hi != 8'h00) bad = 1;
        else if (lo == c8_pkg::LO_CLS) begin
          for (int r = 0; r < c8_pkg::SCREEN_ROWS; r++) sh_screen[r] = '0;
        end else if (lo == c8_pkg::LO_RET) begin
          sh_sp = (sh_sp == 0) ? STACK_N - 1 : sh_sp - 1;
          npc = sh_stack[sh_sp] + 12'd2;
        end else bad = 1;
      end
      c8_pkg::OPG_JP: npc = nnn;
      c8_pkg::OPG_CALL: begin
        sh_stack[sh_sp] = sh_pc;
        sh_sp = (sh_sp + 1 >= STACK_N) ? 0 : sh_sp + 1;
        npc = nnn;
      end
      c8_pkg::OPG_SE: if (vx == lo) npc = skp;
      c8_pkg::OPG_SNE: if (vx != lo) npc = skp;
      c8_pkg::OPG_SER: if (n != 0) bad = 1; else if (vx == vy) npc = skp;
      c8_pkg::OPG_LD: sh_v[x] = lo;
      c8_pkg::OPG_ADD: sh_v[x] = vx + lo;
      c8_pkg::OPG_ALU: begin
        case (n)
          c8_pkg::ALU_MOV: sh_v[x] = vy;
          c8_pkg::ALU_OR:  sh_v[x] = vx | vy;
          c8_pkg::ALU_AND: sh_v[x] = vx & vy;
          c8_pkg::ALU_XOR: sh_v[x] = vx ^ vy;
          c8_pkg::ALU_ADD: begin
            sum = vx + vy; sh_v[x] = sum[7:0]; sh_v[15] = {7'd0, sum[8]};
          end
          c8_pkg::ALU_SUB:  begin sh_v[x] = vx - vy; sh_v[15] = {7'd0, vx >= vy}; end
          c8_pkg::ALU_SHR:  begin sh_v[x] = vx >> 1; sh_v[15] = {7'd0, vx[0]}; end
          c8_pkg::ALU_SUBN: begin sh_v[x] = vy - vx; sh_v[15] = {7'd0, vy >= vx}; end
          c8_pkg::ALU_SHL:  begin sh_v[x] = vx << 1; sh_v[15] = {7'd0, vx[7]}; end
          default: bad = 1;
        endcase
      end
      c8_pkg::OPG_SNER: if (n != 0) bad = 1; else if (vx != vy) npc = skp;
      c8_pkg::OPG_LDI: sh_i = {4'd0, nnn};
      c8_pkg::OPG_JPV: npc = nnn + {4'd0, sh_v[0]};
      c8_pkg::OPG_RND: sh_v[x] = rnd & lo;
      c8_pkg::OPG_DRW: begin
        x0 = vx[5:0]; hit = 0;
        for (int k = 0; k < n; k++) begin
          a = 12'(sh_i + k);
          line = {sh_mem[a], 56'd0};
          line = (line >> x0) | ((x0 == 0) ? 64'd0 : (line << (64 - x0)));
          if ((sh_screen[5'(vy + k)] & line) != 0) hit = 1;
          sh_screen[5'(vy + k)] ^= line;
        end
        sh_v[15] = {7'd0, hit};
      end
      c8_pkg::OPG_KEY: begin
        if (lo == c8_pkg::LO_SKP) begin
          if (sh_keys[vx[3:0]]) npc = skp;
        end else if (lo == c8_pkg::LO_SKNP) begin
          if (!sh_keys[vx[3:0]]) npc = skp;
        end else bad = 1;
      end
      default: begin
        case (lo)
          c8_pkg::LO_WAITK: begin sh_wait = 1; sh_target = x; npc = sh_pc; end
          c8_pkg::LO_TIMER: ;
          c8_pkg::LO_ADDI:  sh_i = sh_i + {8'd0, vx};
          c8_pkg::LO_FONT:  sh_i = 16'(vx[3:0] * 5);
          c8_pkg::LO_BCD: begin
            sh_mem[sh_i[11:0]] = vx / 100;
            sh_mem[12'(sh_i + 1)] = (vx % 100) / 10;
            sh_mem[12'(sh_i + 2)] = vx % 10;
          end
          c8_pkg::LO_STORE: for (int k = 0; k <= x; k++) sh_mem[12'(sh_i + k)] = sh_v[k];
          c8_pkg::LO_LOAD:  for (int k = 0; k <= x; k++) sh_v[k] = sh_mem[12'(sh_i + k)];
          default: bad = 1;
        endcase
      end
    endcase
    if (bad) sh_halt = 1;
    else sh_pc = npc;
  endfunction

  // advance the shadow core by one request and return its result
  function automatic core_result_t shadow_step(logic [2:0] req, logic [11:0] addr,
      logic [7:0] wb, logic [3:0] key, logic down, logic [7:0] rnd, logic [4:0] rsel);
    core_result_t r;
    r = '0;
    case (req)
      c8_pkg::REQ_WRITE: sh_mem[addr] = wb;
      c8_pkg::REQ_READ:  r.rd = sh_mem[addr];
      c8_pkg::REQ_KEY: begin
        if (down) begin
          sh_keys[key] = 1'b1;
          if (sh_wait) begin
            sh_v[sh_target] = {4'd0, key}; sh_wait = 0; sh_pc = sh_pc + 12'd2;
          end
        end else sh_keys[key] = 1'b0;
      end
      c8_pkg::REQ_EXEC: if (!sh_halt && !sh_wait) shadow_execute(rnd);
      c8_pkg::REQ_ROW: r.row = sh_screen[rsel];
      default: ;
    endcase
    r.status = sh_halt ? c8_pkg::ST_HALT : (sh_wait ? c8_pkg::ST_WAIT : c8_pkg::ST_DONE);
    r.pc = sh_pc;
    return r;
  endfunction

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  // send one beat and record its expectation
  task automatic send_request(logic [2:0] req, logic [11:0] addr = 0, logic [7:0] wb = 0,
      logic [3:0] key = 0, logic down = 0, logic [7:0] rnd = 0, logic [4:0] rsel = 0);
    sender_gap();
    in_valid = 1'b1; in_req_type = req; in_mem_addr = addr; in_write_byte = wb;
    in_key_index = key; in_key_down = down; in_random_byte = rnd; in_row_select = rsel;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(shadow_step(req, addr, wb, key, down, rnd, rsel));
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic load_word(logic [11:0] addr, logic [15:0] op);
    send_request(c8_pkg::REQ_WRITE, addr, op[15:8]);
    send_request(c8_pkg::REQ_WRITE, 12'(addr + 1), op[7:0]);
  endtask

  // write opcode at pc then run it
  task automatic run_op(logic [15:0] op, logic [7:0] rnd = 0);
    load_word(sh_pc, op);
    send_request(c8_pkg::REQ_EXEC, 0, 0, 0, 0, rnd);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_start(logic [11:0] value);
    wait_drained();
    cfg_valid = 1'b1; cfg_program_start = value;
    do @(posedge clk); while (!cfg_ready);
    sh_start = value; sh_pc = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    core_result_t got, exp_r;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_read_byte, out_screen_row, out_pc_now};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        beats_checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d rd %h/%h row %h/%h pc %h/%h",
                     exp_r.status, got.status, exp_r.rd, got.rd, exp_r.row, got.row,
                     exp_r.pc, got.pc);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  task automatic test_memory_edges();
    send_request(c8_pkg::REQ_READ, 12'd0);
    send_request(c8_pkg::REQ_READ, 12'd79);
    send_request(c8_pkg::REQ_WRITE, 12'hFFF, 8'hFF);
    send_request(c8_pkg::REQ_READ, 12'hFFF);
    send_request(c8_pkg::REQ_WRITE, 12'h000, 8'h00);
    send_request(c8_pkg::REQ_READ, 12'h000);
    send_request(REQ_UNKNOWN, 12'hABC, 8'h55);
    send_request(c8_pkg::REQ_KEY, 0, 0, 4'hF, 1);
    send_request(c8_pkg::REQ_KEY, 0, 0, 4'hF, 0);
    send_request(c8_pkg::REQ_ROW, 0, 0, 0, 0, 0, 5'd31);
  endtask

  task automatic test_alu();
    run_op(16'h60FF); run_op(16'h6101); run_op(16'h8014);
    run_op(16'h6003); run_op(16'h8015); run_op(16'h8017);
    run_op(16'h6081); run_op(16'h8006); run_op(16'h800E);
    run_op(16'h8211); run_op(16'h8212); run_op(16'h8213); run_op(16'h8210);
    run_op(16'h7F7F); run_op(16'hC5A5, 8'hFF);
  endtask

  task automatic test_flow();
    run_op(16'h3000); run_op(16'h4000); run_op(16'h5010); run_op(16'h9010);
    run_op(16'h2400); run_op(16'h00EE); run_op(16'h00EE);   // underflow wraps
    run_op(16'hB300); run_op(16'h1200);
  endtask

  task automatic test_draw_bcd_mem();
    run_op(16'h603D); run_op(16'h611E); run_op(16'hF029); run_op(16'hD01F);
    run_op(16'hD01F); run_op(16'hD010); run_op(16'hA800); run_op(16'h62FF);
    run_op(16'hF233); run_op(16'hFF55); run_op(16'hFF65); run_op(16'hF21E);
    run_op(16'hF118); run_op(16'h00E0);
    for (int r = 0; r < 4; r++) send_request(c8_pkg::REQ_ROW, 0, 0, 0, 0, 0, 5'(r + 29));
  endtask

  task automatic test_keys();
    send_request(c8_pkg::REQ_KEY, 0, 0, 4'h3, 1);
    run_op(16'h6303); run_op(16'hE39E); run_op(16'hE3A1);
    run_op(16'hF50A);
    send_request(c8_pkg::REQ_EXEC);
    send_request(c8_pkg::REQ_KEY, 0, 0, 4'h9, 0);
    send_request(c8_pkg::REQ_KEY, 0, 0, 4'hA, 1);
  endtask

  task automatic test_halt();
    run_op(16'h0123);
    send_request(c8_pkg::REQ_EXEC);
    send_request(c8_pkg::REQ_READ, 12'h100);
  endtask

  function automatic logic [15:0] random_opcode();
    logic [15:0] op;
    op = 16'($urandom);
    case ($urandom_range(0, 9))
      0: op[15:12] = c8_pkg::OPG_ALU;
      1: op = {c8_pkg::OPG_DRW, op[11:0]};
      2: op = {c8_pkg::OPG_MISC, op[11:8], c8_pkg::LO_STORE};
      3: op = {c8_pkg::OPG_MISC, op[11:8], c8_pkg::LO_LOAD};
      4: op = {c8_pkg::OPG_LDI, 1'b0, op[10:0]};
      5: op = {c8_pkg::OPG_MISC, op[11:8], c8_pkg::LO_BCD};
      default: ;
    endcase
    if (op[15:12] == c8_pkg::OPG_ALU && $urandom_range(0, 9) != 0)
      op[3:0] = (op[3:0] > 4'h7) ? c8_pkg::ALU_SHL : op[3:0];
    if (op[15:12] == c8_pkg::OPG_SYS && $urandom_range(0, 9) != 0)
      op = {8'h00, $urandom_range(0, 1) ? c8_pkg::LO_CLS : c8_pkg::LO_RET};
    return op;
  endfunction

  // random programs; after a halt only host requests are sent, key waits get key events
  task automatic test_random(int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      if (sh_halt) begin
        // a fresh start clears only the pc; halt persists, so run host requests
        case ($urandom_range(0, 3))
          0: send_request(c8_pkg::REQ_WRITE, 12'($urandom), 8'($urandom));
          1: send_request(c8_pkg::REQ_READ, 12'($urandom));
          2: send_request(c8_pkg::REQ_KEY, 0, 0, 4'($urandom), 1'($urandom));
          default: send_request(c8_pkg::REQ_ROW, 0, 0, 0, 0, 0, 5'($urandom));
        endcase
      end else if (sh_wait) send_request(c8_pkg::REQ_KEY, 0, 0, 4'($urandom), 1'($urandom));
      else if ($urandom_range(0, 9) < 7) run_op(random_opcode(), 8'($urandom));
      else send_request(3'($urandom), 12'($urandom), 8'($urandom), 4'($urandom),
                        1'($urandom), 8'($urandom), 5'($urandom));
      sent++;
    end
  endtask

  task automatic test_pause_and_config();
    wait_drained();
    write_start(12'hFFF);
    run_op(16'h6A55);
    write_start(12'h000);
    send_request(c8_pkg::REQ_READ, 12'h000);
    write_start(12'h300);
  endtask

  initial begin
    shadow_reset();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_memory_edges();
    test_alu();
    test_flow();
    test_draw_bcd_mem();
    test_keys();
    test_pause_and_config();
    test_random(220);
    test_halt();
    test_random(80);
    quiet = 1'b1;
    test_random(50);
    wait_drained();
    $display("covered %0d beats: memory, keys, rows, all opcode groups, halts", beats_sent);
    $display("program start written at 0, 0x300 and 0xfff; %0d results checked", beats_checked);
    if (mismatches == 0 && expected_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
